>>> design/touch_pad_state_merger_macros.svh
// Assertion macros for the touch pad state merger.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TOUCH_PAD_STATE_MERGER_MACROS_SVH
`define TOUCH_PAD_STATE_MERGER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define TPSM_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tpsm check failed");
// Next-cycle implication, disabled while reset is asserted.
`define TPSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tpsm check failed");
`else
`define TPSM_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define TPSM_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> design/tpsm_pkg.sv
// Shared types and constants for the touch pad state merger.
// No dependencies; used by every module of the block.
package tpsm_pkg;

    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DZ_W      = 15;
    localparam int BTN_W     = 16;
    localparam int TRIG_W    = 8;
    localparam int AXIS_W    = 16;
    localparam int FINGER_W  = 4;
    localparam int CNT_W     = 32;

    localparam logic [DZ_W-1:0]  DEADZONE_RESET = 15'd7849;
    localparam logic [BTN_W-1:0] BUTTON_MASK_RESET = 16'hF3FF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MASK = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUBLISH    = 2'd0,
        KIND_CLEAR      = 2'd1,
        KIND_MERGE      = 2'd2,
        KIND_SET_ENABLE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [DZ_W-1:0]  deadzone;
        logic [BTN_W-1:0] button_mask;
    } cfg_t;

    // Pad state; axes are left_x, left_y, right_x, right_y from index 0.
    typedef struct packed {
        logic [BTN_W-1:0]           buttons;
        logic [TRIG_W-1:0]          left_trigger;
        logic [TRIG_W-1:0]          right_trigger;
        logic [3:0][AXIS_W-1:0]     axes;
    } pad_t;

    typedef struct packed {
        kind_t               kind;
        pad_t                pad;
        logic [FINGER_W-1:0] fingers_down;
        logic                enable_value;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] press;
        logic [CNT_W-1:0] leak;
        logic [CNT_W-1:0] publish;
        logic [CNT_W-1:0] clear;
    } stats_t;

    typedef struct packed {
        pad_t   pad;
        logic   contributed;
        stats_t stats;
    } result_t;

endpackage

>>> design/tpsm_cfg_regs.sv
// Configuration registers (deadzone and button mask) of the touch pad merger.
// Depends on tpsm_pkg.
module tpsm_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tpsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tpsm_pkg::cfg_t                   cfg
);
    import tpsm_pkg::*;

    logic [DZ_W-1:0]  deadzone_reg;
    logic [BTN_W-1:0] button_mask_reg;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg    <= DEADZONE_RESET;
            button_mask_reg <= BUTTON_MASK_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEADZONE:    deadzone_reg    <= cfg_data[DZ_W-1:0];
                CFG_BUTTON_MASK: button_mask_reg <= cfg_data[BTN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.deadzone    = deadzone_reg;
    assign cfg.button_mask = button_mask_reg;

endmodule

>>> design/tpsm_core.sv
// Snapshot state, statistics counters and merge logic of the touch pad merger.
// Depends on tpsm_pkg; state advances when the top level moves an item on.
module tpsm_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  tpsm_pkg::item_t   item,
    input  tpsm_pkg::cfg_t    cfg,
    output tpsm_pkg::result_t result
);
    import tpsm_pkg::*;

    localparam int POP_W = $clog2(BTN_W + 1);

    pad_t   held_reg, held_next;
    logic   published_reg, published_next;
    logic   enabled_reg, enabled_next;
    stats_t stats_reg, stats_next;

    logic [BTN_W-1:0] new_presses;
    logic [POP_W-1:0] press_count;
    logic             any_control;
    logic             held_any;
    logic             do_contrib;
    logic [AXIS_W-1:0] phys_axis [4];

    // Magnitude of a 16-bit two's complement value; the most negative maps to 0x8000.
    function automatic logic [AXIS_W-1:0] axis_mag(input logic [AXIS_W-1:0] v);
        return v[AXIS_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [POP_W-1:0] n);
        logic [CNT_W:0] sum;
        sum = {1'b0, c} + {{(CNT_W + 1 - POP_W){1'b0}}, n};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    // Bits newly pressed against the stored snapshot, and their count.
    assign new_presses = item.pad.buttons & ~held_reg.buttons;

    always_comb begin
        press_count = '0;
        for (int i = 0; i < BTN_W; i++) begin
            press_count = press_count + POP_W'(new_presses[i]);
        end
    end

    assign any_control = (item.pad != '0);
    assign held_any    = (held_reg != '0);
    assign do_contrib  = enabled_reg && published_reg && held_any;

    // Physical axes with the deadzone applied when the snapshot takes part.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (do_contrib && (axis_mag(item.pad.axes[i]) < {1'b0, cfg.deadzone})) begin
                phys_axis[i] = '0;
            end else begin
                phys_axis[i] = item.pad.axes[i];
            end
        end
    end

    // Next state and the result of the current item.
    always_comb begin
        held_next      = held_reg;
        published_next = published_reg;
        enabled_next   = enabled_reg;
        stats_next     = stats_reg;
        result         = '0;

        case (item.kind)
            KIND_PUBLISH: begin
                stats_next.publish = sat_add(stats_reg.publish, POP_W'(1));
                if ((item.fingers_down == '0) && any_control) begin
                    stats_next.leak = sat_add(stats_reg.leak, POP_W'(1));
                    held_next       = '0;
                end else begin
                    stats_next.press  = sat_add(stats_reg.press, press_count);
                    held_next         = item.pad;
                    held_next.buttons = item.pad.buttons & cfg.button_mask;
                    published_next    = 1'b1;
                end
            end
            KIND_CLEAR: begin
                stats_next.clear = sat_add(stats_reg.clear, POP_W'(1));
                held_next        = '0;
            end
            KIND_SET_ENABLE: begin
                if (item.enable_value != enabled_reg) begin
                    enabled_next = item.enable_value;
                    if (!item.enable_value) begin
                        stats_next.clear = sat_add(stats_reg.clear, POP_W'(1));
                        held_next        = '0;
                    end
                end
            end
            KIND_MERGE: begin
                result.pad = item.pad;
                if (do_contrib) begin
                    result.contributed = 1'b1;
                    result.pad.buttons = item.pad.buttons | held_reg.buttons;
                    if (held_reg.left_trigger > item.pad.left_trigger) begin
                        result.pad.left_trigger = held_reg.left_trigger;
                    end
                    if (held_reg.right_trigger > item.pad.right_trigger) begin
                        result.pad.right_trigger = held_reg.right_trigger;
                    end
                    for (int i = 0; i < 4; i++) begin
                        if (axis_mag(held_reg.axes[i]) > axis_mag(phys_axis[i])) begin
                            result.pad.axes[i] = held_reg.axes[i];
                        end else begin
                            result.pad.axes[i] = phys_axis[i];
                        end
                    end
                end
            end
            default: ;
        endcase

        result.stats = stats_next;
    end

    // State registers move only when an item leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            published_reg <= 1'b0;
            enabled_reg   <= 1'b1;
            stats_reg     <= '0;
        end else if (advance) begin
            held_reg      <= held_next;
            published_reg <= published_next;
            enabled_reg   <= enabled_next;
            stats_reg     <= stats_next;
        end
    end

endmodule

>>> design/touch_pad_state_merger.sv
// Touch pad state merger: keeps one touch overlay pad snapshot and merges it
// into physical pad requests. Every request (publish, clear, merge, set enable)
// gives exactly one result, which passes through the input register and then
// the result register. A new request is taken every cycle while results are
// being drained; throughput is one request per cycle while m_ready is high,
// through the single merge stage between the two registers. Counters
// saturate at all ones. Configuration writes are taken at once and must only
// be issued while no request is in flight.
// Depends on tpsm_pkg, tpsm_cfg_regs, tpsm_core and the assertion macro header.
`include "touch_pad_state_merger_macros.svh"

module touch_pad_state_merger (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tpsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpsm_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tpsm_pkg::KIND_W-1:0]      s_kind,
    input  logic [tpsm_pkg::BTN_W-1:0]       s_buttons,
    input  logic [tpsm_pkg::TRIG_W-1:0]      s_left_trigger,
    input  logic [tpsm_pkg::TRIG_W-1:0]      s_right_trigger,
    input  logic signed [tpsm_pkg::AXIS_W-1:0] s_left_x,
    input  logic signed [tpsm_pkg::AXIS_W-1:0] s_left_y,
    input  logic signed [tpsm_pkg::AXIS_W-1:0] s_right_x,
    input  logic signed [tpsm_pkg::AXIS_W-1:0] s_right_y,
    input  logic [tpsm_pkg::FINGER_W-1:0]    s_fingers_down,
    input  logic                             s_enable_value,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tpsm_pkg::BTN_W-1:0]       m_out_buttons,
    output logic [tpsm_pkg::TRIG_W-1:0]      m_out_left_trigger,
    output logic [tpsm_pkg::TRIG_W-1:0]      m_out_right_trigger,
    output logic signed [tpsm_pkg::AXIS_W-1:0] m_out_left_x,
    output logic signed [tpsm_pkg::AXIS_W-1:0] m_out_left_y,
    output logic signed [tpsm_pkg::AXIS_W-1:0] m_out_right_x,
    output logic signed [tpsm_pkg::AXIS_W-1:0] m_out_right_y,
    output logic                             m_contributed,
    output logic [tpsm_pkg::CNT_W-1:0]       m_press_total,
    output logic [tpsm_pkg::CNT_W-1:0]       m_leak_total,
    output logic [tpsm_pkg::CNT_W-1:0]       m_publish_total,
    output logic [tpsm_pkg::CNT_W-1:0]       m_clear_total
);
    import tpsm_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    // Pack the incoming request fields.
    always_comb begin
        in_item.kind              = kind_t'(s_kind);
        in_item.pad.buttons       = s_buttons;
        in_item.pad.left_trigger  = s_left_trigger;
        in_item.pad.right_trigger = s_right_trigger;
        in_item.pad.axes[0]       = s_left_x;
        in_item.pad.axes[1]       = s_left_y;
        in_item.pad.axes[2]       = s_right_x;
        in_item.pad.axes[3]       = s_right_y;
        in_item.fingers_down      = s_fingers_down;
        in_item.enable_value      = s_enable_value;
    end

    // The held request moves on when the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= in_item;
        end
    end

    tpsm_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpsm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_out_buttons       = out_reg.pad.buttons;
    assign m_out_left_trigger  = out_reg.pad.left_trigger;
    assign m_out_right_trigger = out_reg.pad.right_trigger;
    assign m_out_left_x        = out_reg.pad.axes[0];
    assign m_out_left_y        = out_reg.pad.axes[1];
    assign m_out_right_x       = out_reg.pad.axes[2];
    assign m_out_right_y       = out_reg.pad.axes[3];
    assign m_contributed       = out_reg.contributed;
    assign m_press_total       = out_reg.stats.press;
    assign m_leak_total        = out_reg.stats.leak;
    assign m_publish_total     = out_reg.stats.publish;
    assign m_clear_total       = out_reg.stats.clear;

    // A stalled result is never overwritten by the next request.
    `TPSM_ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, out_valid_reg && !m_ready, !advance)
    // A request leaving the input stage always lands in the result register.
    `TPSM_ASSERT_NEXT(a_result_lands, aclk, aresetn, advance, out_valid_reg)
    // The press, clear and publish counters never go backwards from one result to the next.
    `TPSM_ASSERT_NEXT(a_counters_monotonic, aclk, aresetn, out_valid_reg && advance, (m_press_total >= $past(m_press_total)) && (m_clear_total >= $past(m_clear_total)) && (m_publish_total >= $past(m_publish_total)))

endmodule
